// ===== rtl/cba_pkg.sv =====
// Shared types, constants and helper functions for the calendar boundary advance block.
package cba_pkg;

    typedef enum logic [1:0] {
        REQ_HOUR  = 2'd0,
        REQ_HALF  = 2'd1,
        REQ_DAY   = 2'd2,
        REQ_MONTH = 2'd3
    } t_req;

    localparam logic [3:0] MONTH_JAN  = 4'd0;
    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_DEC  = 4'd11;
    localparam logic [4:0] LAST_HOUR  = 5'd23;
    localparam logic [5:0] HALF_MIN   = 6'd30;
    localparam logic [9:0] YEAR_MAX   = 10'd499;
    localparam logic [8:0] YEAR_LEN   = 9'd365;
    localparam logic [8:0] LEAP_LEN   = 9'd366;

    // century years (offset from 1900) that are not divisible by 400
    localparam logic [8:0] CENT_1900  = 9'd0;
    localparam logic [8:0] CENT_2100  = 9'd200;
    localparam logic [8:0] CENT_2200  = 9'd300;
    localparam logic [8:0] CENT_2300  = 9'd400;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        t_req       req_type;
        logic [8:0] year_off;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
    } t_cba_in;

    typedef struct packed {
        logic [8:0] year_off;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
    } t_cba_out;

    // 1900 is divisible by 4, so the by-4 test runs on the offset directly
    function automatic logic is_leap(input logic [8:0] yoff);
        return (yoff[1:0] == 2'b00) && (yoff != CENT_1900) && (yoff != CENT_2100)
            && (yoff != CENT_2200) && (yoff != CENT_2300);
    endfunction

    // valid for x up to 55
    function automatic logic [2:0] mod7(input logic [5:0] x);
        logic [5:0] v;
        v = x;
        if (v >= 6'd28) v = v - 6'd28;
        if (v >= 6'd14) v = v - 6'd14;
        if (v >= 6'd7)  v = v - 6'd7;
        return v[2:0];
    endfunction

endpackage

// ===== rtl/cba_calc.sv =====
// Combinational boundary computation: hour, half hour, day and month advance.
module cba_calc (
    input  cba_pkg::t_cba_in  i_req,
    output cba_pkg::t_cba_out o_res
);
    import cba_pkg::*;

    logic [3:0] mo;
    logic       leap;
    logic [5:0] dim;
    logic [5:0] day_inc;
    logic [5:0] dd;
    logic [8:0] ylen;
    logic       move;
    logic       new_month;
    logic [5:0] count;
    logic [9:0] yd_sum;
    logic [9:0] year;
    logic       day_step;

    always_comb begin
        mo      = (i_req.month > MONTH_DEC) ? MONTH_DEC : i_req.month;
        leap    = is_leap(i_req.year_off);
        dim     = {1'b0, MONTH_LEN[mo]} + {5'd0, (leap && mo == MONTH_FEB)};
        day_inc = {1'b0, i_req.day_of_month} + 6'd1;
        dd      = ({1'b0, i_req.day_of_month} > dim) ? dim : {1'b0, i_req.day_of_month};
        ylen    = leap ? LEAP_LEN : YEAR_LEN;

        o_res.day_of_month = i_req.day_of_month;
        o_res.hour         = i_req.hour;
        o_res.minute       = i_req.minute;
        o_res.weekday      = i_req.weekday;
        o_res.day_of_year  = i_req.day_of_year;
        move      = 1'b0;
        new_month = 1'b0;
        count     = 6'd1;
        day_step  = 1'b0;

        case (i_req.req_type) inside
            REQ_HOUR, REQ_HALF: begin
                if (i_req.req_type == REQ_HALF && i_req.minute < HALF_MIN) begin
                    o_res.minute = HALF_MIN;
                end else begin
                    o_res.minute = 6'd0;
                    if (i_req.hour >= LAST_HOUR) begin
                        o_res.hour = 5'd0;
                        day_step   = 1'b1;
                    end else begin
                        o_res.hour = i_req.hour + 5'd1;
                    end
                end
            end
            REQ_DAY: begin
                o_res.hour   = 5'd0;
                o_res.minute = 6'd0;
                day_step     = 1'b1;
            end
            default: begin
                o_res.hour   = 5'd0;
                o_res.minute = 6'd0;
                move         = 1'b1;
                new_month    = 1'b1;
                count        = dim - dd + 6'd1;
            end
        endcase

        if (day_step) begin
            move = 1'b1;
            if (day_inc > dim) begin
                new_month = 1'b1;
            end else begin
                o_res.day_of_month = day_inc[4:0];
            end
        end

        // day of year wraps on the length of the year before the move
        yd_sum = {1'b0, i_req.day_of_year} + {4'd0, count};
        if (yd_sum >= {1'b0, ylen}) yd_sum = yd_sum - {1'b0, ylen};
        if (move) begin
            o_res.day_of_year = yd_sum[8:0];
            o_res.weekday     = mod7({3'd0, i_req.weekday} + count);
        end

        year    = {1'b0, i_req.year_off};
        o_res.month = mo;
        if (new_month) begin
            o_res.day_of_month = 5'd1;
            if (mo == MONTH_DEC) begin
                o_res.month = MONTH_JAN;
                year        = year + 10'd1;
            end else begin
                o_res.month = mo + 4'd1;
            end
        end
        o_res.year_off = (year > YEAR_MAX) ? YEAR_MAX[8:0] : year[8:0];
    end

endmodule

// ===== rtl/calendar_boundary_advance.sv =====
// Top level: input register, boundary logic and result register with valid/ready handshakes.
//
//  channel  | valid       | ready        | payload
//  ---------+-------------+--------------+---------------------------------------------
//  request  | i_in_valid  | o_in_ready   | i_req_type, i_year_off .. i_day_of_year
//  result   | o_out_valid | i_out_ready  | o_out_year_off .. o_out_day_of_year
//
// One request per cycle sustained while the result side accepts; a result passes through
// the input register, then the result register, with the calendar logic between them.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
// A stall on the result side fills the input register, then drops o_in_ready.
module calendar_boundary_advance (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [8:0] i_year_off,
    input  logic [3:0] i_month,
    input  logic [4:0] i_day_of_month,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    input  logic [2:0] i_weekday,
    input  logic [8:0] i_day_of_year,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [8:0] o_out_year_off,
    output logic [3:0] o_out_month,
    output logic [4:0] o_out_day_of_month,
    output logic [4:0] o_out_hour,
    output logic [5:0] o_out_minute,
    output logic [2:0] o_out_weekday,
    output logic [8:0] o_out_day_of_year
);
    import cba_pkg::*;

    logic     r_in_valid;
    t_cba_in  r_in;
    logic     r_out_valid;
    t_cba_out r_out;
    t_cba_out calc_res;
    logic     out_stage_ready;
    logic     in_stage_ready;

    cba_calc u_calc (
        .i_req (r_in),
        .o_res (calc_res)
    );

    assign out_stage_ready = !r_out_valid || i_out_ready;
    assign in_stage_ready  = !r_in_valid || out_stage_ready;
    assign o_in_ready      = in_stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_stage_ready) r_in_valid <= i_in_valid;
            if (out_stage_ready) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_stage_ready && i_in_valid) begin
            r_in.req_type     <= t_req'(i_req_type);
            r_in.year_off     <= i_year_off;
            r_in.month        <= i_month;
            r_in.day_of_month <= i_day_of_month;
            r_in.hour         <= i_hour;
            r_in.minute       <= i_minute;
            r_in.weekday      <= i_weekday;
            r_in.day_of_year  <= i_day_of_year;
        end
        if (out_stage_ready && r_in_valid) r_out <= calc_res;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_year_off     = r_out.year_off;
    assign o_out_month        = r_out.month;
    assign o_out_day_of_month = r_out.day_of_month;
    assign o_out_hour         = r_out.hour;
    assign o_out_minute       = r_out.minute;
    assign o_out_weekday      = r_out.weekday;
    assign o_out_day_of_year  = r_out.day_of_year;

endmodule
